[sv/isr_pkg.sv]
// Shared types and constants for the integer square root core.
// Depends on nothing; every other file of the core imports it.
package isr_pkg;

	localparam int ISR_RADICAND_W = 32;
	localparam int ISR_ROOT_W     = 16;
	localparam int ISR_REM_W      = ISR_ROOT_W + 3;
	localparam int ISR_INPUT_BITS = 32;

	typedef struct packed {
		logic                      valid;
		logic [ISR_REM_W-1:0]      rem;
		logic [ISR_ROOT_W-1:0]     acc;
		logic [ISR_RADICAND_W-1:0] radicand;
	} isr_stage_t;

endpackage

[sv/isr_radicand_if.sv]
// Valid/ready channel that carries one radicand per beat.
// Depends on isr_pkg for the field width.
interface isr_radicand_if import isr_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [ISR_RADICAND_W-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink (input valid, input radicand, output ready);
endinterface

[sv/isr_root_if.sv]
// Valid/ready channel that carries one root per beat.
// Depends on isr_pkg for the field width.
interface isr_root_if import isr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ISR_ROOT_W-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink (input valid, input root, output ready);
endinterface

[sv/isr_cell.sv]
// One restoring step of the digit-by-digit square root: brings in one radicand bit pair,
// tries 4*root+1 against the remainder and registers the updated partial result.
// Depends on isr_pkg for the stage record.
module isr_cell import isr_pkg::*; #(
	parameter int PAIR_POS = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  isr_stage_t prev,
	output isr_stage_t next_q
);

	logic [1:0]            pair;
	logic [ISR_REM_W-1:0]  rem_sh;
	logic [ISR_ROOT_W-1:0] acc_base;
	logic [ISR_REM_W-1:0]  trial;
	logic                  fits;

	generate
		if (PAIR_POS < ISR_RADICAND_W) begin : g_pair
			assign pair = prev.radicand[PAIR_POS +: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end
	endgenerate

	always_comb begin
		rem_sh   = {prev.rem[ISR_REM_W-3:0], pair};
		acc_base = {prev.acc[ISR_ROOT_W-2:0], 1'b0};
		trial    = {{(ISR_REM_W-ISR_ROOT_W-1){1'b0}}, acc_base, 1'b1};
		fits     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
		end else if (en) begin
			next_q.valid    <= prev.valid;
			next_q.rem      <= fits ? (rem_sh - trial) : rem_sh;
			next_q.acc      <= {acc_base[ISR_ROOT_W-1:1], fits};
			next_q.radicand <= prev.radicand;
		end
	end

endmodule

[sv/integer_square_root_core.sv]
// Integer square root core: floor(sqrt(radicand)) of a 32-bit unsigned value, 16-bit result.
// Depends on isr_pkg, isr_radicand_if, isr_root_if and isr_cell.
//
// The core is a chain of (INPUT_BITS+1)/2 cells (capped at 32), one per root bit, each of which
// registers its partial root and remainder and hands them to the next cell whenever the chain
// is not held. It accepts one beat per clock while the chain is not held and delivers the roots
// in order, each after it has passed through every cell; the last cell doubles as the output
// register. When the result is not taken the whole chain holds, so the input stalls as well.
// Only the low 2*steps bits of the radicand take part, so a narrow INPUT_BITS gives the root of
// those bits alone. There is no configuration and no state between beats.
module integer_square_root_core import isr_pkg::*; #(
	parameter int INPUT_BITS = ISR_INPUT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	isr_radicand_if.sink          operand,
	isr_root_if.source            result
);

	localparam int STEPS    = ((INPUT_BITS + 1) / 2 > 32) ? 32 : (INPUT_BITS + 1) / 2;
	localparam int EFF_BITS = (2 * STEPS > ISR_RADICAND_W) ? ISR_RADICAND_W : 2 * STEPS;
	localparam logic [ISR_RADICAND_W-1:0] EFF_MASK =
		(EFF_BITS >= ISR_RADICAND_W) ? {ISR_RADICAND_W{1'b1}}
		: ISR_RADICAND_W'((64'd1 << EFF_BITS) - 64'd1);

	isr_stage_t pipe [STEPS+1];
	logic       en;

	assign en            = !pipe[STEPS].valid || result.ready;
	assign operand.ready = en;

	always_comb begin
		pipe[0].valid    = operand.valid;
		pipe[0].rem      = '0;
		pipe[0].acc      = '0;
		pipe[0].radicand = operand.radicand;
	end

	generate
		for (genvar k = 0; k < STEPS; k++) begin : g_cell
			isr_cell #(
				.PAIR_POS (2 * (STEPS - 1 - k))
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.prev   (pipe[k]),
				.next_q (pipe[k+1])
			);
		end
	endgenerate

	assign result.valid = pipe[STEPS].valid;
	assign result.root  = pipe[STEPS].acc;

	logic [ISR_RADICAND_W-1:0] chk_rad;
	logic [2*ISR_ROOT_W+1:0]   chk_sq;
	logic [2*ISR_ROOT_W+1:0]   chk_sq_next;

	always_comb begin
		chk_rad     = pipe[STEPS].radicand & EFF_MASK;
		chk_sq      = (2*ISR_ROOT_W+2)'(pipe[STEPS].acc) * (2*ISR_ROOT_W+2)'(pipe[STEPS].acc);
		chk_sq_next = (2*ISR_ROOT_W+2)'({1'b0, pipe[STEPS].acc} + 17'd1)
			* (2*ISR_ROOT_W+2)'({1'b0, pipe[STEPS].acc} + 17'd1);
	end

	// The delivered root squared never exceeds the radicand.
	a_root_low: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> chk_sq <= (2*ISR_ROOT_W+2)'(chk_rad))
		else $error("root squared exceeds radicand");

	// The next integer squared always exceeds the radicand.
	a_root_high: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> chk_sq_next > (2*ISR_ROOT_W+2)'(chk_rad))
		else $error("root is too small");

	// An accepted beat enters the first cell of the chain.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		operand.valid && operand.ready |=> pipe[1].valid)
		else $error("accepted beat lost at first cell");

	// A root left waiting stays in the last cell unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(pipe[STEPS].radicand))
		else $error("pending root disturbed");

endmodule
